### sv/tts_pkg.sv
// Shared types and constants of the top-three slowest node selector.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int NODE_COUNT = 32;
    localparam int TOP_COUNT  = 3;
    localparam int IDX_W      = 5;
    localparam int TIME_W     = 16;
    localparam int RANK_W     = 15;

    // One incoming item as held in the input register
    typedef struct packed {
        logic [IDX_W-1:0]         node_index;
        logic signed [TIME_W-1:0] beat_time;
        logic                     present;
        logic                     last;
    } t_item;

    // Item step handed to the rank list: valid strobe plus payload
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_step;

    // One slot of the rank list; an empty slot holds index 0 and time 0
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [RANK_W-1:0] rtime;
    } t_entry;

    typedef t_entry [TOP_COUNT-1:0] t_ranks;

endpackage

### sv/tts_if.sv
// Stream channel interfaces for node items and ranking results.
`timescale 1ns / 1ps

interface tts_in_if;
    logic                              valid;
    logic                              ready;
    logic [tts_pkg::IDX_W-1:0]         node_index;
    logic signed [tts_pkg::TIME_W-1:0] beat_time;
    logic                              present;
    logic                              last;

    modport source (output valid, node_index, beat_time, present, last, input ready);
    modport sink   (input valid, node_index, beat_time, present, last, output ready);
endinterface

interface tts_out_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::IDX_W-1:0]  first_index;
    logic [tts_pkg::RANK_W-1:0] first_time;
    logic [tts_pkg::IDX_W-1:0]  second_index;
    logic [tts_pkg::RANK_W-1:0] second_time;
    logic [tts_pkg::IDX_W-1:0]  third_index;
    logic [tts_pkg::RANK_W-1:0] third_time;

    modport source (output valid, first_index, first_time, second_index, second_time,
                    third_index, third_time, input ready);
    modport sink   (input valid, first_index, first_time, second_index, second_time,
                    third_index, third_time, output ready);
endinterface

### sv/tts_rank_list.sv
// Sorted list of the three largest times with insert and clear on last.
`timescale 1ns / 1ps

module tts_rank_list (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tts_pkg::t_step i_step,
    output tts_pkg::t_ranks o_next
);

    tts_pkg::t_ranks                r_ranks;
    tts_pkg::t_ranks                n_ranks;
    logic [tts_pkg::TOP_COUNT-1:0]  gt;
    logic                           take;
    tts_pkg::t_entry                new_entry;

    // Qualify the item: present and a node index inside the node count
    assign take = i_step.valid && i_step.item.present &&
                  ({1'b0, i_step.item.node_index} <
                   (tts_pkg::IDX_W + 1)'(tts_pkg::NODE_COUNT));

    assign new_entry.index = i_step.item.node_index;
    assign new_entry.rtime = i_step.item.beat_time[tts_pkg::RANK_W-1:0];

    // Compare against every slot; strictly greater, so ties keep the older node
    always_comb begin
        for (int k = 0; k < tts_pkg::TOP_COUNT; k++) begin
            gt[k] = take &&
                    (i_step.item.beat_time > $signed({1'b0, r_ranks[k].rtime}));
        end
    end

    // Insert at the first slot exceeded and shift the lower slots down
    always_comb begin
        o_next = r_ranks;
        for (int k = 0; k < tts_pkg::TOP_COUNT; k++) begin
            if (k == 0) begin
                if (gt[k]) begin
                    o_next[k] = new_entry;
                end
            end else if (gt[k-1]) begin
                o_next[k] = r_ranks[k-1];
            end else if (gt[k]) begin
                o_next[k] = new_entry;
            end
        end
    end

    // Clear the list once a round closes
    always_comb begin
        n_ranks = o_next;
        if (i_step.valid && i_step.item.last) begin
            n_ranks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranks <= '0;
        end else if (i_step.valid) begin
            r_ranks <= n_ranks;
        end
    end

endmodule

### sv/top_three_slowest_selector_core.sv
// Top level of the top-three slowest node selector.
//
// Usage: stream one item per node on i_in (node_index, beat_time, present, last).
// Present items with an index below the node count and a positive time compete
// for a sorted list of the three largest times; equal times keep the earlier node.
// The item that carries last closes the round: one result on o_out gives the
// three index/time pairs, largest first, with 0/0 for slots left empty, and
// the list is cleared for the next round.
// An item is registered at the input register and then applied to the rank list;
// a round's result is registered in the result register as its last item is applied.
// Throughput: one item per cycle while no last item waits on a held result; the
// rank list compares and shifts between the input and result registers.
// Stall: while o_out waits, items without last keep flowing; a last item waits
// in the input register until the result register frees.
// Reset (i_rst_n low, synchronous): empties both registers and the rank list.
`timescale 1ns / 1ps

module top_three_slowest_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tts_in_if.sink      i_in,
    tts_out_if.source   o_out
);

    logic            r_in_valid;
    tts_pkg::t_item  r_in;
    logic            r_out_valid;
    tts_pkg::t_ranks r_out;
    logic            advance;
    tts_pkg::t_step  step;
    tts_pkg::t_ranks next_ranks;

    // Advance the held item unless it closes a round and the result is still held
    assign advance = r_in_valid && (!r_in.last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Hold the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.node_index <= i_in.node_index;
            r_in.beat_time  <= i_in.beat_time;
            r_in.present    <= i_in.present;
            r_in.last       <= i_in.last;
        end
    end

    assign step.valid = advance;
    assign step.item  = r_in;

    tts_rank_list u_rank_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_next  (next_ranks)
    );

    // Capture the result when a round closes; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= next_ranks;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.first_index  = r_out[0].index;
    assign o_out.first_time   = r_out[0].rtime;
    assign o_out.second_index = r_out[1].index;
    assign o_out.second_time  = r_out[1].rtime;
    assign o_out.third_index  = r_out[2].index;
    assign o_out.third_time   = r_out[2].rtime;

endmodule
